// ===== rtl/rfpc_pkg.sv =====
// ----------------------------------------------------------------------------
// rfpc_pkg
// Shared constants, types and the CRC15 byte step for the readback frame
// PEC checker.
// ----------------------------------------------------------------------------
package rfpc_pkg;

    localparam int MAX_DEVICES_DEF = 16;

    localparam logic [15:0] PEC_INIT = 16'h0010;
    localparam logic [15:0] PEC_POLY = 16'h4599;

    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;
    localparam int DEV_CNT_W  = 5;

    localparam logic [APB_ADDR_W-1:0] ADDR_DEVICE_COUNT = 2'd0;

    // Byte offsets inside one device frame.
    localparam logic [2:0] POS_PEC_HIGH = 3'd6;
    localparam logic [2:0] POS_PEC_LOW  = 3'd7;

    typedef enum logic
    {
        KIND_CODE = 1'b0,
        KIND_PEC  = 1'b1
    } result_kind_t;

    typedef struct packed
    {
        result_kind_t kind;
        logic [3:0]   device_index;
        logic [3:0]   channel_index;
        logic [15:0]  code_value;
        logic         pec_ok;
        logic         any_pec_error;
        logic         last;
    } result_t;

    // One byte of the CRC15: table index from the top remainder bits, then
    // eight polynomial steps on the 15-bit entry.
    function automatic logic [15:0] crc_byte(input logic [15:0] rem,
                                             input logic [7:0]  data);
        logic [15:0] r;
        r = {1'b0, rem[14:7] ^ data, 7'b0};
        for (int b = 0; b < 8; b++)
        begin
            if (r[14])
                r = {r[14:0], 1'b0} ^ PEC_POLY;
            else
                r = {r[14:0], 1'b0};
        end
        return {rem[7:0], 8'h00} ^ r;
    endfunction

endpackage

// ===== rtl/rfpc_frame_if.sv =====
// ----------------------------------------------------------------------------
// rfpc_frame_if
// Request channel carrying one received readback byte with its framing.
// ----------------------------------------------------------------------------
interface rfpc_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       start_of_read;
    logic [2:0] group;

    modport source (output valid, output rx_byte, output start_of_read,
                    output group, input ready);
    modport sink   (input valid, input rx_byte, input start_of_read,
                    input group, output ready);
endinterface

// ===== rtl/rfpc_result_if.sv =====
// ----------------------------------------------------------------------------
// rfpc_result_if
// Request channel carrying one code or PEC check result.
// ----------------------------------------------------------------------------
interface rfpc_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [3:0]  device_index;
    logic [3:0]  channel_index;
    logic [15:0] code_value;
    logic        pec_ok;
    logic        any_pec_error;
    logic        last;

    modport source (output valid, output kind, output device_index,
                    output channel_index, output code_value, output pec_ok,
                    output any_pec_error, output last, input ready);
    modport sink   (input valid, input kind, input device_index,
                    input channel_index, input code_value, input pec_ok,
                    input any_pec_error, input last, output ready);
endinterface

// ===== rtl/rfpc_core.sv =====
// ----------------------------------------------------------------------------
// rfpc_core
// Frame parser state: byte position, device counter, running CRC and held
// bytes. Produces the result of the current byte combinationally.
// ----------------------------------------------------------------------------
module rfpc_core
    import rfpc_pkg::*;
#(
    parameter int MAX_DEVICES = MAX_DEVICES_DEF,
    localparam int CNT_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       rx_byte,
    input  logic             start_of_read,
    input  logic [2:0]       group,
    input  logic [CNT_W:0]   eff_count,
    output logic             res_valid,
    output result_t          res
);

    logic [2:0]       pos_reg,    pos_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;
    logic [15:0]      crc_reg,    crc_next;
    logic [7:0]       low_reg,    low_next;
    logic [7:0]       pec_hi_reg, pec_hi_next;
    logic             sticky_reg, sticky_next;
    logic [2:0]       grp_reg,    grp_next;

    logic [2:0]       pos;
    logic [CNT_W-1:0] cnt;
    logic [15:0]      crc;
    logic             sticky;
    logic [2:0]       grp;
    logic [3:0]       base;
    logic [15:0]      rx_pec;
    logic             ok;
    logic             is_last;

    always_comb
    begin
        // A start restarts the frame before this byte is parsed.
        pos    = start_of_read ? 3'd0 : pos_reg;
        cnt    = start_of_read ? '0 : cnt_reg;
        crc    = start_of_read ? PEC_INIT : crc_reg;
        sticky = start_of_read ? 1'b0 : sticky_reg;
        grp    = start_of_read ? group : grp_reg;

        // Aux groups, and the unused codes above them, start from channel zero.
        base = grp[2] ? 4'({2'b00, grp[1:0]} * 4'd3) : 4'({1'b0, grp} * 4'd3);

        rx_pec  = {pec_hi_reg, rx_byte};
        ok      = (rx_pec == {crc[14:0], 1'b0});
        is_last = ((CNT_W+1)'(cnt) + (CNT_W+1)'(1)) >= eff_count;

        pos_next    = pos;
        cnt_next    = cnt;
        crc_next    = crc;
        low_next    = low_reg;
        pec_hi_next = pec_hi_reg;
        sticky_next = sticky;
        grp_next    = grp;

        res_valid         = 1'b0;
        res.kind          = KIND_CODE;
        res.device_index  = 4'(cnt);
        res.channel_index = base + 4'(pos[2:1]);
        res.code_value    = {rx_byte, low_reg};
        res.pec_ok        = 1'b0;
        res.any_pec_error = sticky;
        res.last          = 1'b0;

        if (pos < POS_PEC_HIGH)
        begin
            crc_next = crc_byte(crc, rx_byte);
            pos_next = pos + 3'd1;
            if (!pos[0])
                low_next = rx_byte;
            else
                res_valid = 1'b1;
        end
        else if (pos == POS_PEC_HIGH)
        begin
            pec_hi_next = rx_byte;
            pos_next    = POS_PEC_LOW;
        end
        else
        begin
            res_valid         = 1'b1;
            res.kind          = KIND_PEC;
            res.channel_index = 4'd0;
            res.code_value    = rx_pec;
            res.pec_ok        = ok;
            res.any_pec_error = sticky | ~ok;
            res.last          = is_last;
            sticky_next       = sticky | ~ok;
            cnt_next          = is_last ? '0 : cnt + CNT_W'(1);
            pos_next          = 3'd0;
            crc_next          = PEC_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 3'd0;
            cnt_reg    <= '0;
            crc_reg    <= PEC_INIT;
            low_reg    <= 8'h00;
            pec_hi_reg <= 8'h00;
            sticky_reg <= 1'b0;
            grp_reg    <= 3'd0;
        end
        else if (accept)
        begin
            pos_reg    <= pos_next;
            cnt_reg    <= cnt_next;
            crc_reg    <= crc_next;
            low_reg    <= low_next;
            pec_hi_reg <= pec_hi_next;
            sticky_reg <= sticky_next;
            grp_reg    <= grp_next;
        end
    end

    // The CRC restarts after every PEC byte.
    a_crc_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (pos == POS_PEC_LOW) |=> (crc_reg == PEC_INIT) && (pos_reg == 3'd0))
        else $error("CRC not restarted after PEC byte");

    // The sticky error never clears without a start.
    a_sticky_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sticky_reg && !(accept && start_of_read) |=> sticky_reg)
        else $error("sticky error dropped without a start");

    // The device counter wraps on the last device.
    a_cnt_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res_valid && res.last |=> (cnt_reg == '0))
        else $error("device counter did not wrap after last device");

endmodule

// ===== rtl/readback_frame_pec_checker.sv =====
// ----------------------------------------------------------------------------
// readback_frame_pec_checker
// Checks daisy-chain register-group readbacks byte by byte.
// ----------------------------------------------------------------------------
// The frame channel takes one received byte per request, with start_of_read
// set on the first byte of a group read and group naming the group read.
// Each device sends three little-endian codes and a big-endian PEC.
// The result channel returns a code request after bytes 1, 3 and 5 of each
// device and a PEC check request after byte 7; other bytes return nothing.
// The result of a byte is registered and valid the cycle after the byte
// is taken. Throughput is one byte per cycle while results are not held,
// set by the single CRC byte step between the parser state and the output
// register. The next byte is taken in the same cycle that a held result is
// taken. When the receiver stalls with a result held, frame.ready drops
// until it is taken.
// The APB port holds device_count at address 0 (reset 1); write it only
// while the block is idle. Reset clears the parser, the CRC to its initial
// value and the output valid flag; the block takes bytes right after reset.
// ----------------------------------------------------------------------------
module readback_frame_pec_checker
    import rfpc_pkg::*;
#(
    parameter int MAX_DEVICES = MAX_DEVICES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    rfpc_frame_if.sink            frame,
    rfpc_result_if.source         result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CNT_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;

    logic [DEV_CNT_W-1:0] dev_count_reg;
    logic [CNT_W:0]       eff_count;
    logic                 accept;
    logic                 in_ready;
    logic                 core_valid;
    result_t              core_res;
    logic                 out_valid_reg;
    result_t              out_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_DEVICE_COUNT) ? APB_DATA_W'(dev_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dev_count_reg <= DEV_CNT_W'(1);
        else if (psel && penable && pwrite && pready && (paddr == ADDR_DEVICE_COUNT))
            dev_count_reg <= pwdata[DEV_CNT_W-1:0];
    end

    always_comb
    begin
        if (dev_count_reg == '0)
            eff_count = (CNT_W+1)'(1);
        else if (int'(dev_count_reg) > MAX_DEVICES)
            eff_count = (CNT_W+1)'(MAX_DEVICES);
        else
            eff_count = (CNT_W+1)'(dev_count_reg);
    end

    assign in_ready    = !out_valid_reg || result.ready;
    assign frame.ready = in_ready;
    assign accept      = frame.valid && in_ready;

    rfpc_core #(
        .MAX_DEVICES (MAX_DEVICES)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .rx_byte       (frame.rx_byte),
        .start_of_read (frame.start_of_read),
        .group         (frame.group),
        .eff_count     (eff_count),
        .res_valid     (core_valid),
        .res           (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_ready)
            out_valid_reg <= accept && core_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && accept && core_valid)
            out_reg <= core_res;
    end

    assign result.valid         = out_valid_reg;
    assign result.kind          = out_reg.kind;
    assign result.device_index  = out_reg.device_index;
    assign result.channel_index = out_reg.channel_index;
    assign result.code_value    = out_reg.code_value;
    assign result.pec_ok        = out_reg.pec_ok;
    assign result.any_pec_error = out_reg.any_pec_error;
    assign result.last          = out_reg.last;

    // A failed PEC always shows in the sticky flag of the same result.
    a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.kind == KIND_PEC) && !out_reg.pec_ok
        |-> out_reg.any_pec_error)
        else $error("PEC failure without sticky error");

    // Code results carry neither pec_ok nor last.
    a_code_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.kind == KIND_CODE) |-> !out_reg.pec_ok && !out_reg.last)
        else $error("code result with check flags set");

    // A held result is not overwritten by a new byte.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |-> !accept)
        else $error("byte taken while result stalled");

endmodule
